// File: rtl/transpose_self_organizing_search_unit_defines.svh
// Assertion macros for the transpose self-organizing search unit.
`ifndef TRANSPOSE_SELF_ORGANIZING_SEARCH_UNIT_DEFINES_SVH
`define TRANSPOSE_SELF_ORGANIZING_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTH
`define TSOS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tsos assertion failed");
`define TSOS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tsos assertion failed");
`else
`define TSOS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define TSOS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/tsos_pkg.sv
// Shared types and codes for the transpose self-organizing search unit.
package tsos_pkg;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int ENTRY_W  = KEY_W + VALUE_W;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_SCAN,
        S_SWAP_UP,
        S_SWAP_DN,
        S_RD_WAIT,
        S_RESP
    } state_t;

endpackage

// File: rtl/tsos_in_if.sv
// Request channel: operation beat into the search unit.
interface tsos_in_if;
    logic                             valid;
    logic                             ready;
    logic [tsos_pkg::FUNC_W-1:0]      func;
    logic [tsos_pkg::KEY_W-1:0]       key;
    logic [tsos_pkg::VALUE_W-1:0]     value;
    logic [tsos_pkg::POS_W-1:0]       position;

    modport source (output valid, func, key, value, position, input ready);
    modport sink   (input valid, func, key, value, position, output ready);
endinterface

// File: rtl/tsos_out_if.sv
// Response channel: result beat out of the search unit.
interface tsos_out_if;
    logic                             valid;
    logic                             ready;
    logic [tsos_pkg::STATUS_W-1:0]    status;
    logic [tsos_pkg::KEY_W-1:0]       found_key;
    logic [tsos_pkg::VALUE_W-1:0]     found_value;
    logic [tsos_pkg::POS_W-1:0]       hit_position;
    logic [tsos_pkg::COUNT_W-1:0]     entry_count;

    modport source (output valid, status, found_key, found_value, hit_position, entry_count,
                    input ready);
    modport sink   (input valid, status, found_key, found_value, hit_position, entry_count,
                    output ready);
endinterface

// File: rtl/tsos_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module tsos_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/transpose_self_organizing_search_unit.sv
// Top level: ordered key/value table with front insert and transpose-on-hit search.
//
//  channel | dir | payload                                              | handshake
//  --------+-----+------------------------------------------------------+------------
//  req     | in  | func, key, value, position                           | valid/ready
//  rsp     | out | status, found_key, found_value, hit_position,        | valid/ready
//          |     | entry_count                                          |
//
// One operation at a time; req.ready is high only while the sequencer is idle.
// Search reads the table one entry per cycle through the single registered RAM read
// port and compares each key as its data returns; a hit behind the front is written
// back swapped with its front neighbour, and then the response register is loaded.
// The table is a circular buffer, so an insert only moves the head pointer.
// No clearing pass after reset. A stalled rsp holds the sequencer in its response state.
`include "transpose_self_organizing_search_unit_defines.svh"

module transpose_self_organizing_search_unit #(
    parameter int DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    tsos_in_if.sink    req,
    tsos_out_if.source rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    tsos_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                   head_reg, head_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [tsos_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [tsos_pkg::VALUE_W-1:0]    val_reg, val_next;
    logic [tsos_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [AW-1:0]                   hpos_reg, hpos_next;
    logic [CW-1:0]                   iss_idx_reg, iss_idx_next;
    logic                            cmp_v_reg, cmp_v_next;
    logic [AW-1:0]                   cmp_idx_reg, cmp_idx_next;
    logic [tsos_pkg::ENTRY_W-1:0]    prev_reg, prev_next;

    logic                            out_valid_reg, out_valid_next;
    logic [tsos_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [tsos_pkg::KEY_W-1:0]      out_key_reg, out_key_next;
    logic [tsos_pkg::VALUE_W-1:0]    out_val_reg, out_val_next;
    logic [tsos_pkg::POS_W-1:0]      out_pos_reg, out_pos_next;
    logic [tsos_pkg::COUNT_W-1:0]    out_cnt_reg, out_cnt_next;

    // shared logical-to-physical address unit
    logic [AW-1:0]                   idx_sel;
    logic [AW:0]                     addr_sum;
    logic [AW-1:0]                   phys_addr;
    logic [AW-1:0]                   head_dec;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [tsos_pkg::ENTRY_W-1:0]    ram_wdata;
    logic [AW-1:0]                   ram_raddr;
    logic [tsos_pkg::ENTRY_W-1:0]    ram_rdata;
    logic [tsos_pkg::KEY_W-1:0]      rd_key;
    logic [tsos_pkg::VALUE_W-1:0]    rd_val;

    assign addr_sum  = {1'b0, head_reg} + {1'b0, idx_sel};
    assign phys_addr = (addr_sum >= DEPTH_W) ? AW'(addr_sum - DEPTH_W) : AW'(addr_sum);
    assign head_dec  = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);

    assign rd_key = ram_rdata[tsos_pkg::ENTRY_W-1:tsos_pkg::VALUE_W];
    assign rd_val = ram_rdata[tsos_pkg::VALUE_W-1:0];

    tsos_ram #(
        .WIDTH (tsos_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == tsos_pkg::S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        status_next     = status_reg;
        hpos_next       = hpos_reg;
        iss_idx_next    = iss_idx_reg;
        cmp_v_next      = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        prev_next       = prev_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_val_next    = out_val_reg;
        out_pos_next    = out_pos_reg;
        out_cnt_next    = out_cnt_reg;
        idx_sel         = '0;
        ram_we          = 1'b0;
        ram_waddr       = head_dec;
        ram_wdata       = {key_reg, val_reg};
        ram_raddr       = phys_addr;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tsos_pkg::S_IDLE:
            begin
                idx_sel = AW'(req.position);
                if (req.valid)
                begin
                    key_next    = req.key;
                    val_next    = req.value;
                    status_next = tsos_pkg::STATUS_OK;
                    hpos_next   = '0;
                    unique case (req.func)
                        tsos_pkg::FUNC_INSERT:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = tsos_pkg::STATUS_FULL;
                                key_next    = '0;
                                val_next    = '0;
                                state_next  = tsos_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = tsos_pkg::S_INS;
                            end
                        end
                        tsos_pkg::FUNC_SEARCH:
                        begin
                            iss_idx_next = '0;
                            if (count_reg == '0)
                            begin
                                status_next = tsos_pkg::STATUS_NOT_FOUND;
                                key_next    = '0;
                                val_next    = '0;
                                state_next  = tsos_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = tsos_pkg::S_SCAN;
                            end
                        end
                        tsos_pkg::FUNC_READ:
                        begin
                            if (32'(req.position) < 32'(count_reg))
                            begin
                                // read issued this cycle through the address unit
                                hpos_next  = AW'(req.position);
                                state_next = tsos_pkg::S_RD_WAIT;
                            end
                            else
                            begin
                                status_next = tsos_pkg::STATUS_RANGE;
                                key_next    = '0;
                                val_next    = '0;
                                state_next  = tsos_pkg::S_RESP;
                            end
                        end
                        default:
                        begin
                            key_next   = '0;
                            val_next   = '0;
                            state_next = tsos_pkg::S_RESP;
                        end
                    endcase
                end
            end

            tsos_pkg::S_INS:
            begin
                ram_we     = 1'b1;
                ram_waddr  = head_dec;
                head_next  = head_dec;
                count_next = count_reg + CW'(1);
                state_next = tsos_pkg::S_RESP;
            end

            tsos_pkg::S_RD_WAIT:
            begin
                key_next   = rd_key;
                val_next   = rd_val;
                state_next = tsos_pkg::S_RESP;
            end

            tsos_pkg::S_SCAN:
            begin
                // issue side: one read per cycle until the count is reached
                idx_sel = iss_idx_reg[AW-1:0];
                if (iss_idx_reg < count_reg)
                begin
                    iss_idx_next = iss_idx_reg + CW'(1);
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = iss_idx_reg[AW-1:0];
                end
                // compare side: data of the read issued last cycle
                if (cmp_v_reg)
                begin
                    if (rd_key == key_reg)
                    begin
                        key_next    = rd_key;
                        val_next    = rd_val;
                        hpos_next   = cmp_idx_reg;
                        status_next = tsos_pkg::STATUS_OK;
                        cmp_v_next  = 1'b0;
                        state_next  = (cmp_idx_reg == '0) ? tsos_pkg::S_RESP
                                                          : tsos_pkg::S_SWAP_UP;
                    end
                    else
                    begin
                        prev_next = ram_rdata;
                        if (CW'(cmp_idx_reg) + CW'(1) == count_reg)
                        begin
                            status_next = tsos_pkg::STATUS_NOT_FOUND;
                            key_next    = '0;
                            val_next    = '0;
                            hpos_next   = '0;
                            cmp_v_next  = 1'b0;
                            state_next  = tsos_pkg::S_RESP;
                        end
                    end
                end
            end

            tsos_pkg::S_SWAP_UP:
            begin
                idx_sel    = hpos_reg - AW'(1);
                ram_we     = 1'b1;
                ram_waddr  = phys_addr;
                ram_wdata  = {key_reg, val_reg};
                state_next = tsos_pkg::S_SWAP_DN;
            end

            tsos_pkg::S_SWAP_DN:
            begin
                idx_sel    = hpos_reg;
                ram_we     = 1'b1;
                ram_waddr  = phys_addr;
                ram_wdata  = prev_reg;
                state_next = tsos_pkg::S_RESP;
            end

            tsos_pkg::S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_key_next    = key_reg;
                    out_val_next    = val_reg;
                    out_pos_next    = tsos_pkg::POS_W'(hpos_reg);
                    out_cnt_next    = tsos_pkg::COUNT_W'(count_reg);
                    state_next      = tsos_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tsos_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsos_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            iss_idx_reg   <= '0;
            cmp_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            iss_idx_reg   <= iss_idx_next;
            cmp_v_reg     <= cmp_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        val_reg        <= val_next;
        status_reg     <= status_next;
        hpos_reg       <= hpos_next;
        cmp_idx_reg    <= cmp_idx_next;
        prev_reg       <= prev_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_val_reg    <= out_val_next;
        out_pos_reg    <= out_pos_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_key    = out_key_reg;
    assign rsp.found_value  = out_val_reg;
    assign rsp.hit_position = out_pos_reg;
    assign rsp.entry_count  = out_cnt_reg;

    `TSOS_ASSERT_SAME(a_count_max, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `TSOS_ASSERT_SAME(a_head_range, clk, rst_n, 1'b1, head_reg <= LAST_IDX)
    `TSOS_ASSERT_NEXT(a_ins_count, clk, rst_n, state_reg == tsos_pkg::S_INS, count_reg == $past(count_reg) + CW'(1))
    `TSOS_ASSERT_SAME(a_swap_not_front, clk, rst_n, state_reg == tsos_pkg::S_SWAP_UP, hpos_reg != '0)
    `TSOS_ASSERT_SAME(a_cmp_in_table, clk, rst_n, state_reg == tsos_pkg::S_SCAN && cmp_v_reg, CW'(cmp_idx_reg) < count_reg)

endmodule

// File: tb/transpose_self_organizing_search_unit_tb.sv
// Self-checking testbench for the transpose self-organizing search unit.
`timescale 1ns / 100ps

module transpose_self_organizing_search_unit_tb;
    import tsos_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;
    localparam int BLOCKS       = 12;
    localparam int BLOCK_ITEMS  = 120;
    localparam int MAX_PRINTED  = 100;

    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

    localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] ALT_A    = 64'h5555_5555_5555_5555;
    localparam logic [KEY_W-1:0] ALT_B    = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } op_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    hit_pos;
        logic [COUNT_W-1:0]  count;
    } result_t;

    typedef struct {
        op_beat_t op;
        bit       has_want;
        result_t  want;
    } script_row_t;

    logic clk;
    logic rst_n;

    tsos_in_if  req_if ();
    tsos_out_if rsp_if ();

    transpose_self_organizing_search_unit #(
        .DEPTH (TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the table
    logic [KEY_W-1:0]   tbl_keys   [TABLE_DEPTH];
    logic [VALUE_W-1:0] tbl_values [TABLE_DEPTH];
    int                 tbl_count;

    result_t pending_results [$];

    int error_count;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int hold_left;
    int cycle_count;

    int n_inserts, n_full, n_searches, n_hits, n_moved, n_reads, n_range, n_nop;

    script_row_t directed_ops [15];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("MISMATCH @%0t: %s got %h want %h", $time, what, got, want);
    endtask

    // Applies one operation to the shadow table and returns the response it yields.
    function automatic result_t apply_op(input op_beat_t op);
        result_t            r;
        int                 hit;
        logic [KEY_W-1:0]   fk;
        logic [VALUE_W-1:0] fv;
        r = '0;
        hit = -1;
        case (op.func)
            FUNC_INSERT:
            begin
                n_inserts++;
                if (tbl_count >= TABLE_DEPTH)
                begin
                    r.status = STATUS_FULL;
                    n_full++;
                end
                else
                begin
                    for (int i = tbl_count; i > 0; i--)
                    begin
                        tbl_keys[i]   = tbl_keys[i-1];
                        tbl_values[i] = tbl_values[i-1];
                    end
                    tbl_keys[0]   = op.key;
                    tbl_values[0] = op.value;
                    tbl_count++;
                    r.status = STATUS_OK;
                    r.key    = op.key;
                    r.value  = op.value;
                end
            end
            FUNC_SEARCH:
            begin
                n_searches++;
                for (int i = 0; i < tbl_count && hit < 0; i++)
                    if (tbl_keys[i] == op.key)
                        hit = i;
                if (hit < 0)
                    r.status = STATUS_NOT_FOUND;
                else
                begin
                    n_hits++;
                    fk = tbl_keys[hit];
                    fv = tbl_values[hit];
                    // transpose: hit trades places with its front neighbor
                    if (hit > 0)
                    begin
                        n_moved++;
                        tbl_keys[hit]     = tbl_keys[hit-1];
                        tbl_values[hit]   = tbl_values[hit-1];
                        tbl_keys[hit-1]   = fk;
                        tbl_values[hit-1] = fv;
                    end
                    r.status  = STATUS_OK;
                    r.key     = fk;
                    r.value   = fv;
                    r.hit_pos = hit[POS_W-1:0];
                end
            end
            FUNC_READ:
            begin
                n_reads++;
                if (op.position < tbl_count)
                begin
                    r.status  = STATUS_OK;
                    r.key     = tbl_keys[op.position];
                    r.value   = tbl_values[op.position];
                    r.hit_pos = op.position;
                end
                else
                begin
                    r.status = STATUS_RANGE;
                    n_range++;
                end
            end
            default:
                n_nop++;
        endcase
        r.count = tbl_count[COUNT_W-1:0];
        return r;
    endfunction

    // Mostly searches for stored keys and reads of live positions; inserts are
    // rare enough that the table fills partway through the run.
    function automatic op_beat_t make_random_op();
        op_beat_t op;
        int       roll;
        int       pick;
        op.key      = {$urandom, $urandom};
        op.value    = {$urandom, $urandom};
        op.position = POS_W'($urandom_range(63));
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        if (roll < 14)
        begin
            op.func = FUNC_INSERT;
            if (tbl_count > 0 && pick < 25)
                op.key = tbl_keys[$urandom_range(tbl_count - 1)];
        end
        else if (roll < 62)
        begin
            op.func = FUNC_SEARCH;
            if (tbl_count > 0 && pick < 60)
                op.key = tbl_keys[$urandom_range(tbl_count - 1)];
            else if (tbl_count > 0 && pick < 75)
                op.key = tbl_keys[$urandom_range(tbl_count - 1)]
                         ^ (64'd1 << $urandom_range(63));
        end
        else if (roll < 94)
        begin
            op.func = FUNC_READ;
            if (tbl_count > 0 && pick < 75)
                op.position = POS_W'($urandom_range(tbl_count - 1));
        end
        else
            op.func = FUNC_NOP;
        return op;
    endfunction

    task automatic send_op(input op_beat_t op, input bit has_want, input result_t want);
        result_t predicted;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.func     <= op.func;
        req_if.key      <= op.key;
        req_if.value    <= op.value;
        req_if.position <= op.position;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predicted = apply_op(op);
        pending_results.push_back(has_want ? want : predicted);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("response beat with nothing pending", rsp_if.status, 0);
            return;
        end
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status)
            report_mismatch("status", rsp_if.status, want.status);
        if (rsp_if.found_key !== want.key)
            report_mismatch("found_key", rsp_if.found_key, want.key);
        if (rsp_if.found_value !== want.value)
            report_mismatch("found_value", rsp_if.found_value, want.value);
        if (rsp_if.hit_position !== want.hit_pos)
            report_mismatch("hit_position", rsp_if.hit_position, want.hit_pos);
        if (rsp_if.entry_count !== want.count)
            report_mismatch("entry_count", rsp_if.entry_count, want.count);
    endtask

    initial
    begin : response_sink
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
                check_result();
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, pending_results.size());
        $display("** transpose_self_organizing_search_unit: FAILED **");
        $finish;
    end

    initial
    begin : op_source
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        hold_left      = 0;
        tbl_count      = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_keys[i]   = '0;
            tbl_values[i] = '0;
        end

        // empty table, then the field extremes, duplicates, transposes, range edge
        directed_ops[0]  = '{'{FUNC_READ, 64'd0, 64'd0, 6'd0}, 1'b1,
                             '{STATUS_RANGE, 64'd0, 64'd0, 6'd0, 7'd0}};
        directed_ops[1]  = '{'{FUNC_SEARCH, ALL_ONES, 64'd0, 6'd0}, 1'b1,
                             '{STATUS_NOT_FOUND, 64'd0, 64'd0, 6'd0, 7'd0}};
        directed_ops[2]  = '{'{FUNC_NOP, ALT_A, ALT_B, 6'd63}, 1'b1,
                             '{STATUS_OK, 64'd0, 64'd0, 6'd0, 7'd0}};
        directed_ops[3]  = '{'{FUNC_INSERT, ALL_ONES, 64'd0, 6'd63}, 1'b1,
                             '{STATUS_OK, ALL_ONES, 64'd0, 6'd0, 7'd1}};
        directed_ops[4]  = '{'{FUNC_INSERT, 64'd0, ALL_ONES, 6'd0}, 1'b1,
                             '{STATUS_OK, 64'd0, ALL_ONES, 6'd0, 7'd2}};
        directed_ops[5]  = '{'{FUNC_INSERT, ALT_A, ALT_B, 6'd21}, 1'b1,
                             '{STATUS_OK, ALT_A, ALT_B, 6'd0, 7'd3}};
        directed_ops[6]  = '{'{FUNC_INSERT, ALL_ONES, 64'd1, 6'd42}, 1'b1,
                             '{STATUS_OK, ALL_ONES, 64'd1, 6'd0, 7'd4}};
        directed_ops[7]  = '{'{FUNC_SEARCH, ALL_ONES, 64'd0, 6'd0}, 1'b0, '0};
        directed_ops[8]  = '{'{FUNC_SEARCH, 64'd0, ALL_ONES, 6'd0}, 1'b0, '0};
        directed_ops[9]  = '{'{FUNC_SEARCH, 64'd0, 64'd0, 6'd63}, 1'b0, '0};
        directed_ops[10] = '{'{FUNC_READ, ALL_ONES, ALL_ONES, 6'd3}, 1'b0, '0};
        directed_ops[11] = '{'{FUNC_READ, 64'd0, 64'd0, 6'd4}, 1'b1,
                             '{STATUS_RANGE, 64'd0, 64'd0, 6'd0, 7'd4}};
        directed_ops[12] = '{'{FUNC_READ, 64'd0, 64'd0, 6'd63}, 1'b1,
                             '{STATUS_RANGE, 64'd0, 64'd0, 6'd0, 7'd4}};
        directed_ops[13] = '{'{FUNC_SEARCH, ALT_B, 64'd0, 6'd0}, 1'b1,
                             '{STATUS_NOT_FOUND, 64'd0, 64'd0, 6'd0, 7'd4}};
        directed_ops[14] = '{'{FUNC_SEARCH, 64'd0, 64'd0, 6'd0}, 1'b0, '0};

        rst_n           <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.func     <= FUNC_NOP;
        req_if.key      <= '0;
        req_if.value    <= '0;
        req_if.position <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ops[i])
            send_op(directed_ops[i].op, directed_ops[i].has_want, directed_ops[i].want);

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            case (blk % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            // long response stall while requests keep coming
            if (blk == 4)
                hold_request = 1'b1;
            // let the unit go fully idle before carrying on
            if (blk == 8)
                drain_results();
            for (int n = 0; n < BLOCK_ITEMS; n++)
                send_op(make_random_op(), 1'b0, '0);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d inserts (%0d on a full table), %0d searches (%0d hits, %0d moved up),",
                 n_inserts, n_full, n_searches, n_hits, n_moved);
        $display("%0d reads (%0d out of range), %0d unused-code beats; %0d cycles, %0d errors",
                 n_reads, n_range, n_nop, cycle_count, error_count);
        if (error_count == 0)
            $display("** transpose_self_organizing_search_unit: PASSED **");
        else
            $display("** transpose_self_organizing_search_unit: FAILED **");
        $finish;
    end

endmodule
